// ===== hdl/rjb_pkg.sv =====
// rjb_pkg: shared constants and types of the rtp jitter reorder buffer
// no dependencies; used by rjb_out_stage and rtp_jitter_reorder_buffer
`default_nettype none
package rjb_pkg;
  localparam int STORE_DEPTH = 32;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_NACK_GAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_GAP = 1'b1;

  localparam logic [5:0] NACK_GAP_RESET = 6'd16;
  localparam logic [7:0] SKIP_GAP_RESET = 8'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  localparam logic [1:0] KIND_MISSING = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_seq;
    logic [31:0] out_handle;
    logic        store_full;
    logic [31:0] lost_total;
    logic [31:0] received_total;
    logic        last;
  } rjb_res_t;
endpackage
`default_nettype wire

// ===== hdl/rjb_if.sv =====
// rjb_in_if and rjb_out_if: valid/ready channels of the jitter buffer
// no dependencies
`default_nettype none
interface rjb_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] seq_number;
  logic [31:0] packet_handle;
  modport source (output valid, output operation, output seq_number,
                  output packet_handle, input ready);
  modport sink (input valid, input operation, input seq_number,
                input packet_handle, output ready);
endinterface

interface rjb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] out_seq;
  logic [31:0] out_handle;
  logic        store_full;
  logic [31:0] lost_total;
  logic [31:0] received_total;
  logic        last;
  modport source (output valid, output kind, output out_seq, output out_handle,
                  output store_full, output lost_total, output received_total,
                  output last, input ready);
  modport sink (input valid, input kind, input out_seq, input out_handle,
                input store_full, input lost_total, input received_total,
                input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/rjb_out_stage.sv =====
// rjb_out_stage: output register between the sequencer and the result channel
// depends on rjb_pkg and rjb_out_if
`default_nettype none
module rjb_out_stage
  import rjb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     em_valid_i,
  input  wire rjb_res_t em_item_i,
  output logic          em_ready_o,
  rjb_out_if.source     out_o
);
  logic     vld_q, vld_d;
  rjb_res_t item_q;

  assign em_ready_o = !vld_q || out_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (out_o.ready) vld_d = 1'b0;
    if (em_valid_i && em_ready_o) vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_valid_i && em_ready_o) item_q <= em_item_i;
  end

  assign out_o.valid          = vld_q;
  assign out_o.kind           = item_q.kind;
  assign out_o.out_seq        = item_q.out_seq;
  assign out_o.out_handle     = item_q.out_handle;
  assign out_o.store_full     = item_q.store_full;
  assign out_o.lost_total     = item_q.lost_total;
  assign out_o.received_total = item_q.received_total;
  assign out_o.last           = item_q.last;
endmodule
`default_nettype wire

// ===== hdl/rtp_jitter_reorder_buffer.sv =====
// rtp_jitter_reorder_buffer: rtp reorder store with loss reports and release
// depends on rjb_pkg, rjb_if and rjb_out_stage
//
// in_i carries insert or consume transactions; out_o returns result
// transactions, the last one of each input flagged by last. cfg_we_i writes
// nack_gap_limit (index 0) or skip_gap_limit (index 1); the user must write
// only while idle; the block does not enforce it. One input is worked on at
// a time; in_i.ready is high only when idle. The packet store is one memory
// of STORE_DEPTH words, read one word a cycle, with valid bits in flip-flops.
// Insert: an accept step, the missing reports, a duplicate scan of the store,
// a write step and the end item.
// Consume: one scan of the store per stored packet plus one, each pick
// followed by a decision step.
// Reset empties the store and waits for the first insert; no clearing pass.
// A stalled receiver holds the sequencer at the next result; one finished
// result waits in the output register while the block takes the next input.
`default_nettype none
module rtp_jitter_reorder_buffer
  import rjb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  rjb_in_if.sink                     in_i,
  rjb_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MISS  = 3'd1;
  localparam logic [2:0] ST_DSCAN = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_CSCAN = 3'd4;
  localparam logic [2:0] ST_CDEC  = 3'd5;
  localparam logic [2:0] ST_END   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [5:0] nack_q;
  logic [7:0] skip_q;
  logic       await_q, await_d;
  logic [15:0] exp_q, exp_d, oseq_q, oseq_d;
  logic [31:0] lost_q, lost_d, recv_q, recv_d;
  logic [STORE_DEPTH-1:0] valid_q, valid_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] handle_q, handle_d;
  logic        full_q, full_d;
  logic [15:0] mbase_q, mbase_d;
  logic [5:0]  mnum_q, mnum_d, mi_q, mi_d;
  logic [CNT_W-1:0] scnt_q, scnt_d;
  logic        rvld_q, rvld_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic        dup_q, dup_d;
  logic [IDX_W-1:0] didx_q, didx_d;
  logic        bv_q, bv_d, pv_q, pv_d;
  logic [15:0] bseq_q, bseq_d, prev_q, prev_d;
  logic [31:0] bhnd_q, bhnd_d;
  logic [IDX_W-1:0] bidx_q, bidx_d;

  // store memory: {seq, handle}
  logic [47:0] mem [STORE_DEPTH];
  logic [47:0] rdata_q;
  logic        rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [47:0] wdata;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wdata;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  logic     em_valid, em_ready;
  rjb_res_t em_item;

  rjb_out_stage u_out (
    .clk_i, .rst_ni,
    .em_valid_i (em_valid),
    .em_item_i  (em_item),
    .em_ready_o (em_ready),
    .out_o      (out_o)
  );

  // lowest free slot
  logic             free_v;
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    free_v = 1'b0;
    free_idx = '0;
    for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_v = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  logic        accept;
  logic [15:0] diff, rdiff;
  logic [32:0] lsum;
  logic        scan_done;
  logic [15:0] r_seq;
  logic        release_ok;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign diff       = in_i.seq_number - exp_q;
  assign lsum       = {1'b0, lost_q} + {18'b0, diff[14:0]};
  assign scan_done  = (scnt_q == CNT_W'(STORE_DEPTH)) && !rvld_q;
  assign r_seq      = rdata_q[47:32];
  assign rdiff      = bseq_q - oseq_q;
  assign release_ok = rdiff[15] || (rdiff == 16'd0) ||
                      (rdiff[14:0] <= {7'b0, skip_q});

  always_comb begin
    state_d = state_q; await_d = await_q; exp_d = exp_q; oseq_d = oseq_q;
    lost_d = lost_q; recv_d = recv_q; valid_d = valid_q;
    seq_d = seq_q; handle_d = handle_q; full_d = full_q;
    mbase_d = mbase_q; mnum_d = mnum_q; mi_d = mi_q;
    scnt_d = scnt_q; rvld_d = 1'b0; ridx_d = ridx_q;
    dup_d = dup_q; didx_d = didx_q;
    bv_d = bv_q; pv_d = pv_q; bseq_d = bseq_q; prev_d = prev_q;
    bhnd_d = bhnd_q; bidx_d = bidx_q;
    rd_en = 1'b0; rd_addr = scnt_q[IDX_W-1:0];
    wr_en = 1'b0; wr_addr = free_idx; wdata = {seq_q, handle_q};
    em_valid = 1'b0;
    em_item.kind = KIND_END;
    em_item.out_seq = 16'd0;
    em_item.out_handle = 32'd0;
    em_item.store_full = 1'b0;
    em_item.lost_total = lost_q;
    em_item.received_total = recv_q;
    em_item.last = 1'b0;

    // shared memory walk
    if (state_q == ST_DSCAN || state_q == ST_CSCAN) begin
      if (scnt_q != CNT_W'(STORE_DEPTH)) begin
        rd_en = 1'b1;
        scnt_d = scnt_q + CNT_W'(1);
        rvld_d = 1'b1;
        ridx_d = scnt_q[IDX_W-1:0];
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          full_d = 1'b0;
          seq_d = in_i.seq_number;
          handle_d = in_i.packet_handle;
          scnt_d = '0;
          if (in_i.operation == OP_INSERT) begin
            mnum_d = 6'd0;
            mi_d = 6'd0;
            dup_d = 1'b0;
            if (recv_q != 32'hFFFF_FFFF) recv_d = recv_q + 32'd1;
            if (await_q) begin
              exp_d = in_i.seq_number + 16'd1;
              oseq_d = in_i.seq_number;
              await_d = 1'b0;
            end else begin
              if (!diff[15] && diff != 16'd0) begin
                lost_d = lsum[32] ? 32'hFFFF_FFFF : lsum[31:0];
                if (diff[14:0] <= {9'b0, nack_q}) begin
                  mnum_d = diff[5:0];
                  mbase_d = exp_q;
                end
              end
              if (!diff[15]) exp_d = in_i.seq_number + 16'd1;
            end
            if (!await_q && !diff[15] && diff != 16'd0 &&
                diff[14:0] <= {9'b0, nack_q}) begin
              state_d = ST_MISS;
            end else begin
              state_d = ST_DSCAN;
            end
          end else begin
            pv_d = 1'b0;
            bv_d = 1'b0;
            state_d = ST_CSCAN;
          end
        end
      end
      ST_MISS: begin
        em_valid = 1'b1;
        em_item.kind = KIND_MISSING;
        em_item.out_seq = mbase_q + {10'b0, mi_q};
        if (em_ready) begin
          mi_d = mi_q + 6'd1;
          if (mi_q + 6'd1 == mnum_q) state_d = ST_DSCAN;
        end
      end
      ST_DSCAN: begin
        if (rvld_q && valid_q[ridx_q] && r_seq == seq_q) begin
          dup_d = 1'b1;
          didx_d = ridx_q;
        end
        if (scan_done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (dup_q) begin
          wr_en = 1'b1;
          wr_addr = didx_q;
        end else if (free_v) begin
          wr_en = 1'b1;
          valid_d[free_idx] = 1'b1;
        end else begin
          full_d = 1'b1;
        end
        state_d = ST_END;
      end
      ST_CSCAN: begin
        // smallest stored number above the last one picked
        if (rvld_q && valid_q[ridx_q] && (!pv_q || r_seq > prev_q) &&
            (!bv_q || r_seq < bseq_q)) begin
          bv_d = 1'b1;
          bseq_d = r_seq;
          bhnd_d = rdata_q[31:0];
          bidx_d = ridx_q;
        end
        if (scan_done) begin
          if (bv_q) begin
            pv_d = 1'b1;
            prev_d = bseq_q;
            state_d = ST_CDEC;
          end else begin
            state_d = ST_END;
          end
        end
      end
      ST_CDEC: begin
        if (release_ok) begin
          em_valid = 1'b1;
          em_item.kind = KIND_RELEASE;
          em_item.out_seq = bseq_q;
          em_item.out_handle = bhnd_q;
          if (em_ready) begin
            oseq_d = bseq_q + 16'd1;
            valid_d[bidx_q] = 1'b0;
            bv_d = 1'b0;
            scnt_d = '0;
            state_d = ST_CSCAN;
          end
        end else begin
          bv_d = 1'b0;
          scnt_d = '0;
          state_d = ST_CSCAN;
        end
      end
      ST_END: begin
        em_valid = 1'b1;
        em_item.kind = KIND_END;
        em_item.store_full = full_q;
        em_item.last = 1'b1;
        if (em_ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nack_q <= NACK_GAP_RESET;
      skip_q <= SKIP_GAP_RESET;
      await_q <= 1'b1;
      exp_q <= 16'd0;
      oseq_q <= 16'd0;
      lost_q <= 32'd0;
      recv_q <= 32'd0;
      valid_q <= '0;
      scnt_q <= '0;
      rvld_q <= 1'b0;
      dup_q <= 1'b0;
      bv_q <= 1'b0;
      pv_q <= 1'b0;
      full_q <= 1'b0;
      mnum_q <= 6'd0;
      mi_q <= 6'd0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == CFG_NACK_GAP) nack_q <= cfg_wdata_i[5:0];
      if (cfg_we_i && cfg_idx_i == CFG_SKIP_GAP) skip_q <= cfg_wdata_i;
      await_q <= await_d;
      exp_q <= exp_d;
      oseq_q <= oseq_d;
      lost_q <= lost_d;
      recv_q <= recv_d;
      valid_q <= valid_d;
      scnt_q <= scnt_d;
      rvld_q <= rvld_d;
      dup_q <= dup_d;
      bv_q <= bv_d;
      pv_q <= pv_d;
      full_q <= full_d;
      mnum_q <= mnum_d;
      mi_q <= mi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    handle_q <= handle_d;
    mbase_q <= mbase_d;
    ridx_q <= ridx_d;
    didx_q <= didx_d;
    bseq_q <= bseq_d;
    prev_q <= prev_d;
    bhnd_q <= bhnd_d;
    bidx_q <= bidx_d;
  end
endmodule
`default_nettype wire
